@@ design/shs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shs_pkg
// shared types and constants of the chained string hash set
// ----------------------------------------------------------------------------
package shs_pkg;

    localparam int BUCKETS   = 64;
    localparam int NODES     = 256;
    localparam int KEY_BYTES = 30;

    localparam int BKT_W   = $clog2(BUCKETS);
    localparam int BCNT_W  = 7;
    localparam int NODE_W  = $clog2(NODES);
    localparam int USED_W  = NODE_W + 1;
    localparam int LEN_W   = $clog2(KEY_BYTES + 1);
    localparam int CHAR_AW = $clog2(NODES * KEY_BYTES);
    localparam int LINK_W  = 1 + NODE_W + LEN_W;
    localparam int HASH_W  = 32;

    localparam logic [11:0] HASH_MULT = 12'd2137;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_LOOKUP = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_POOL     = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;
    localparam logic [1:0] ST_NO_BKT   = 2'd3;

    typedef struct packed {
        logic [1:0]        action;
        logic signed [7:0] char_code;
        logic              last;
    } t_in_word;

    typedef struct packed {
        logic       found;
        logic [1:0] status;
    } t_out_word;

endpackage

@@ design/string_hash_set_chained_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_hash_set_chained_core
// chained hash set of short keys held in bucket, link and character rams
// ----------------------------------------------------------------------------
// a non-final character is folded into the hash and key buffer in idle,
// where clear and error results are also given; at key end the serial
// remainder picks the bucket, then insert links a node and copies the key,
// lookup reads the head, then per node a link and each compared character
// reset clears bucket valid flops, pool count and key state at once
module string_hash_set_chained_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  shs_pkg::t_in_word     i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output shs_pkg::t_out_word    o_out_word,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [1:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import shs_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MOD   = 3'd1;
    localparam logic [2:0] S_HEAD  = 3'd2;
    localparam logic [2:0] S_HWAIT = 3'd3;
    localparam logic [2:0] S_LWAIT = 3'd4;
    localparam logic [2:0] S_CCMP  = 3'd5;
    localparam logic [2:0] S_COPY  = 3'd6;

    logic [2:0]         r_state, n_state;
    logic [BCNT_W-1:0]  r_bcnt;
    logic [BCNT_W-1:0]  w_nb;
    logic [HASH_W-1:0]  r_hash, n_hash;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [7:0]         r_kbuf [KEY_BYTES];
    logic [1:0]         r_act;
    logic [BKT_W-1:0]   r_bkt;
    logic [BUCKETS-1:0] r_bvalid;
    logic [USED_W-1:0]  r_used;
    logic [NODE_W-1:0]  r_node, n_node;
    logic [LEN_W-1:0]   r_ci, n_ci;
    logic               r_lv;
    logic [NODE_W-1:0]  r_lnk;
    logic               r_out_valid;
    t_out_word          r_out;

    logic               w_accept, w_emit, w_found, w_clear, w_div_start, w_div_done;
    logic [1:0]         w_status;
    logic [BKT_W-1:0]   w_rem;
    logic               w_kb_we, w_head_we, w_link_we, w_char_we, w_bset;
    logic [NODE_W-1:0]  w_head_rd;
    logic [LINK_W-1:0]  w_link_rd;
    logic [7:0]         w_char_rd;
    logic [CHAR_AW-1:0] w_base, w_char_addr;
    logic [HASH_W-1:0]  w_cext;
    logic               w_rlv;
    logic [NODE_W-1:0]  w_rlnk;
    logic [LEN_W-1:0]   w_rlen;

    assign pready = 1'b1;
    assign prdata = {{(32 - BCNT_W){1'b0}}, r_bcnt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcnt <= BCNT_W'(BUCKETS);
        end else if (psel && penable && pwrite) begin
            r_bcnt <= pwdata[BCNT_W-1:0];
        end
    end

    assign w_nb = (r_bcnt > BCNT_W'(BUCKETS)) ? BCNT_W'(BUCKETS) : r_bcnt;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_cext = {{(HASH_W - 8){i_in_word.char_code[7]}}, i_in_word.char_code};
    assign w_rlv  = w_link_rd[LINK_W-1];
    assign w_rlnk = w_link_rd[LINK_W-2:LEN_W];
    assign w_rlen = w_link_rd[LEN_W-1:0];
    assign w_base = CHAR_AW'(r_node) * CHAR_AW'(KEY_BYTES);

    always_comb begin
        n_state     = r_state;
        n_hash      = r_hash;
        n_len       = r_len;
        n_node      = r_node;
        n_ci        = r_ci;
        w_emit      = 1'b0;
        w_found     = 1'b0;
        w_status    = ST_OK;
        w_clear     = 1'b0;
        w_div_start = 1'b0;
        w_kb_we     = 1'b0;
        w_head_we   = 1'b0;
        w_link_we   = 1'b0;
        w_char_we   = 1'b0;
        w_bset      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_in_word.action == ACT_CLEAR) begin
                    w_clear = 1'b1;
                    w_emit  = 1'b1;
                end else if (w_accept && i_in_word.action != ACT_NONE) begin
                    n_hash  = r_hash * HASH_W'(HASH_MULT) + w_cext;
                    w_kb_we = r_len < LEN_W'(KEY_BYTES - 1);
                    if (r_len < LEN_W'(KEY_BYTES)) begin
                        n_len = r_len + 1'b1;
                    end
                    if (i_in_word.last) begin
                        if (n_len > LEN_W'(KEY_BYTES - 1)) begin
                            w_emit   = 1'b1;
                            w_status = ST_TOO_LONG;
                        end else if (w_nb == '0) begin
                            w_emit   = 1'b1;
                            w_status = ST_NO_BKT;
                        end else if (i_in_word.action == ACT_INSERT &&
                                     r_used >= USED_W'(NODES)) begin
                            w_emit   = 1'b1;
                            w_status = ST_POOL;
                        end else begin
                            w_div_start = 1'b1;
                            n_state     = S_MOD;
                        end
                    end
                end
            end
            S_MOD: begin
                if (w_div_done) begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                n_state = S_HWAIT;
            end
            S_HWAIT: begin
                if (r_act == ACT_INSERT) begin
                    n_node    = r_used[NODE_W-1:0];
                    w_link_we = 1'b1;
                    w_head_we = 1'b1;
                    w_bset    = 1'b1;
                    n_ci      = '0;
                    n_state   = S_COPY;
                end else if (!r_bvalid[r_bkt]) begin
                    w_emit = 1'b1;
                end else begin
                    n_node  = w_head_rd;
                    n_state = S_LWAIT;
                end
            end
            S_COPY: begin
                w_char_we = 1'b1;
                n_ci      = r_ci + 1'b1;
                if (r_ci == r_len - 1'b1) begin
                    w_emit = 1'b1;
                end
            end
            S_LWAIT: begin
                if (w_rlen != r_len) begin
                    if (!w_rlv) begin
                        w_emit = 1'b1;
                    end else begin
                        n_node = w_rlnk;
                    end
                end else begin
                    n_ci    = '0;
                    n_state = S_CCMP;
                end
            end
            S_CCMP: begin
                if (w_char_rd != r_kbuf[r_ci]) begin
                    if (!r_lv) begin
                        w_emit = 1'b1;
                    end else begin
                        n_node  = r_lnk;
                        n_state = S_LWAIT;
                    end
                end else if (r_ci == r_len - 1'b1) begin
                    w_emit  = 1'b1;
                    w_found = 1'b1;
                end else begin
                    n_ci = r_ci + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_emit) begin
            n_state = S_IDLE;
            n_hash  = '0;
            n_len   = '0;
        end
    end

    assign w_char_addr = w_base + CHAR_AW'((r_state == S_COPY) ? r_ci : n_ci);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hash      <= '0;
            r_len       <= '0;
            r_bvalid    <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hash  <= n_hash;
            r_len   <= n_len;
            if (w_clear) begin
                r_bvalid <= '0;
                r_used   <= '0;
            end else if (w_bset) begin
                r_bvalid[r_bkt] <= 1'b1;
                r_used          <= r_used + 1'b1;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_node <= n_node;
        r_ci   <= n_ci;
        if (w_kb_we) begin
            r_kbuf[r_len] <= i_in_word.char_code;
        end
        if (w_accept) begin
            r_act <= i_in_word.action;
        end
        if (w_div_done) begin
            r_bkt <= w_rem;
        end
        if (r_state == S_LWAIT) begin
            r_lv  <= w_rlv;
            r_lnk <= w_rlnk;
        end
        if (w_emit) begin
            r_out.found  <= w_found;
            r_out.status <= w_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    shs_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (n_hash),
        .i_divisor  (w_nb),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    shs_ram #(.WIDTH(NODE_W), .DEPTH(BUCKETS)) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (w_head_we),
        .i_waddr (r_bkt),
        .i_wdata (r_used[NODE_W-1:0]),
        .i_raddr (r_bkt),
        .o_rdata (w_head_rd)
    );

    shs_ram #(.WIDTH(LINK_W), .DEPTH(NODES)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_link_we),
        .i_waddr (r_used[NODE_W-1:0]),
        .i_wdata ({r_bvalid[r_bkt], w_head_rd, r_len}),
        .i_raddr (n_node),
        .o_rdata (w_link_rd)
    );

    shs_ram #(.WIDTH(8), .DEPTH(NODES * KEY_BYTES)) u_char_ram (
        .i_clk   (i_clk),
        .i_we    (w_char_we),
        .i_waddr (w_char_addr),
        .i_wdata (r_kbuf[r_ci]),
        .i_raddr (w_char_addr),
        .o_rdata (w_char_rd)
    );

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(NODES))
        else $error("node count beyond pool");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == S_IDLE)
        else $error("input taken while busy");
    a_div_in_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_MOD)
        else $error("remainder done outside wait");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit && r_state != S_IDLE |-> !r_out_valid)
        else $error("result overwrites pending word");
`endif

endmodule

@@ design/shs_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shs_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module shs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/shs_mod.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shs_mod
// bit serial remainder of the 32 bit hash by the bucket count
// ----------------------------------------------------------------------------
module shs_mod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [shs_pkg::HASH_W-1:0]  i_dividend,
    input  logic [shs_pkg::BCNT_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [shs_pkg::BKT_W-1:0]   o_rem
);
    import shs_pkg::*;

    localparam int CNT_W = $clog2(HASH_W);

    logic [HASH_W-1:0] r_q;
    logic [BKT_W-1:0]  r_rem, n_rem;
    logic [BCNT_W-1:0] r_div;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy, r_done;
    logic [BKT_W:0]    w_t;

    always_comb begin
        w_t = {r_rem, r_q[HASH_W-1]};
        if (w_t >= r_div) begin
            w_t = w_t - r_div;
        end
        n_rem = w_t[BKT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(HASH_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[HASH_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ verif/string_hash_set_chained_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_hash_set_chained_core_test
// streams keys one character per word into the chained hash set and checks
// every clear, insert and lookup result against an in-bench model of the
// table, across several bucket counts, pool exhaustion and output stalls
// ----------------------------------------------------------------------------
module string_hash_set_chained_core_test;
    import shs_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_word    i_in_word;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_word   o_out_word;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    string_hash_set_chained_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_word(o_out_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    localparam int LIMIT = 3000000;

    // model of the table
    logic [6:0]  bucket_sel;
    logic [7:0]  pend_key [KEY_BYTES];
    int unsigned pend_len;
    logic [31:0] pend_hash;
    int          chain_head [BUCKETS];
    int          chain_next [NODES];
    logic [7:0]  stored_key [NODES][KEY_BYTES];
    int unsigned stored_len [NODES];
    int unsigned pool_used;

    t_out_word   expected_q [$];
    int          mismatches;
    int          cycles;
    bit          out_hold;
    bit          idle_on;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("string_hash_set_chained_core_test failed");
            $finish;
        end
    end

    function automatic bit keys_equal(int n);
        if (stored_len[n] != pend_len) return 1'b0;
        for (int k = 0; k < pend_len; k++)
            if (stored_key[n][k] != pend_key[k]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void predict_word(t_in_word w);
        t_out_word   r;
        int unsigned nb;
        int unsigned b;
        int          n;
        r = '0;
        if (w.action == ACT_NONE) return;
        if (w.action == ACT_CLEAR) begin
            for (int k = 0; k < BUCKETS; k++) chain_head[k] = -1;
            pool_used = 0;
            pend_len = 0;
            pend_hash = '0;
            expected_q.push_back(r);
            return;
        end
        pend_hash = pend_hash * 32'd2137 + {{24{w.char_code[7]}}, w.char_code};
        if (pend_len < KEY_BYTES - 1) pend_key[pend_len] = w.char_code;
        if (pend_len < KEY_BYTES) pend_len++;
        if (!w.last) return;
        nb = (bucket_sel > BUCKETS) ? BUCKETS : bucket_sel;
        if (pend_len > KEY_BYTES - 1) r.status = ST_TOO_LONG;
        else if (nb == 0) r.status = ST_NO_BKT;
        else begin
            b = pend_hash % nb;
            if (w.action == ACT_INSERT) begin
                if (pool_used >= NODES) r.status = ST_POOL;
                else begin
                    for (int k = 0; k < pend_len; k++) stored_key[pool_used][k] = pend_key[k];
                    stored_len[pool_used] = pend_len;
                    chain_next[pool_used] = chain_head[b];
                    chain_head[b] = pool_used;
                    pool_used++;
                end
            end else begin
                n = chain_head[b];
                while (n >= 0) begin
                    if (keys_equal(n)) begin
                        r.found = 1'b1;
                        break;
                    end
                    n = chain_next[n];
                end
            end
        end
        pend_len = 0;
        pend_hash = '0;
        expected_q.push_back(r);
    endfunction

    task automatic send_word(logic [1:0] act, logic [7:0] ch, logic lst);
        t_in_word w;
        w.action = act;
        w.char_code = ch;
        w.last = lst;
        while (idle_on && $urandom_range(99) < 17) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_word(w);
    endtask

    task automatic send_key(logic [1:0] act, logic [7:0] s [$]);
        foreach (s[k]) send_word(act, s[k], k == s.size() - 1);
    endtask

    task automatic wait_drained;
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_buckets(logic [6:0] v);
        wait_drained();
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= 2'd0; pwdata <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        bucket_sel = v;
    endtask

    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %p", o_out_word);
            end else begin
                e = expected_q.pop_front();
                if (o_out_word.found !== e.found || o_out_word.status !== e.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", e, o_out_word);
                end
            end
        end
    end

    always @(posedge i_clk)
        i_out_ready <= !out_hold && !(idle_on && $urandom_range(99) < 17);

    function automatic void random_key(ref logic [7:0] s [$], input int len, input int pool);
        s = {};
        for (int k = 0; k < len; k++)
            s.push_back(pool == 0 ? 8'($urandom_range(255))
                                  : 8'(8'h61 + $urandom_range(pool - 1)));
    endfunction

    task automatic test_directed;
        logic [7:0] s [$];
        send_word(ACT_INSERT, 8'h7f, 1'b1);
        send_word(ACT_LOOKUP, 8'h7f, 1'b1);
        send_word(ACT_LOOKUP, 8'h80, 1'b1);
        send_key(ACT_INSERT, '{8'h00, 8'h80, 8'hff});
        send_key(ACT_LOOKUP, '{8'h00, 8'h80, 8'hff});
        send_key(ACT_INSERT, '{8'h00, 8'h80, 8'hff});
        send_word(ACT_INSERT, 8'h41, 1'b0);
        send_word(ACT_LOOKUP, 8'h41, 1'b1);
        send_word(ACT_NONE, 8'h55, 1'b1);
        send_word(ACT_LOOKUP, 8'h41, 1'b1);
        random_key(s, KEY_BYTES - 1, 0);
        send_key(ACT_INSERT, s);
        send_key(ACT_LOOKUP, s);
        random_key(s, KEY_BYTES, 0);
        send_key(ACT_INSERT, s);
        random_key(s, KEY_BYTES + 3, 0);
        send_key(ACT_LOOKUP, s);
        send_word(ACT_INSERT, 8'h12, 1'b0);
        send_word(ACT_CLEAR, 8'hff, 1'b1);
        send_word(ACT_LOOKUP, 8'h7f, 1'b1);
    endtask

    task automatic test_bucket_counts;
        write_buckets(7'd0);
        send_word(ACT_INSERT, 8'h33, 1'b1);
        send_word(ACT_LOOKUP, 8'h33, 1'b1);
        write_buckets(7'd127);
        send_word(ACT_INSERT, 8'h33, 1'b1);
        send_word(ACT_LOOKUP, 8'h33, 1'b1);
        write_buckets(7'd1);
        send_word(ACT_LOOKUP, 8'h33, 1'b1);
        send_word(ACT_INSERT, 8'h44, 1'b1);
        send_word(ACT_LOOKUP, 8'h44, 1'b1);
    endtask

    task automatic test_pool_full;
        logic [7:0] s [$];
        send_word(ACT_CLEAR, 8'h00, 1'b1);
        for (int i = 0; i < NODES + 4; i++) begin
            random_key(s, 1 + $urandom_range(2), 4);
            send_key(ACT_INSERT, s);
        end
        random_key(s, KEY_BYTES + 1, 4);
        send_key(ACT_INSERT, s);
        send_word(ACT_LOOKUP, 8'h61, 1'b1);
    endtask

    task automatic test_random(int words, logic [6:0] nb);
        logic [7:0] s [$];
        int sent;
        int r;
        write_buckets(nb);
        send_word(ACT_CLEAR, 8'h00, 1'b1);
        sent = 0;
        while (sent < words) begin
            r = $urandom_range(99);
            if (r < 2) begin
                send_word(ACT_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
                sent++;
            end else if (r < 5) begin
                send_word(ACT_NONE, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end else if (r < 10) begin
                random_key(s, 1 + $urandom_range(KEY_BYTES + 3), 0);
                send_key(2'($urandom_range(1, 2)), s);
                sent += s.size();
            end else begin
                random_key(s, 1 + $urandom_range(3), 3);
                send_key(r < 50 ? ACT_INSERT : ACT_LOOKUP, s);
                sent += s.size();
            end
        end
    endtask

    task automatic test_backpressure;
        logic [7:0] s [$];
        idle_on = 1'b0;
        fork
            begin
                out_hold = 1'b1;
                repeat (600) @(posedge i_clk);
                out_hold = 1'b0;
            end
            for (int i = 0; i < 40; i++) begin
                random_key(s, 1 + $urandom_range(2), 3);
                send_key(i % 2 ? ACT_LOOKUP : ACT_INSERT, s);
            end
        join
        idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_out_ready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        cycles = 0;
        mismatches = 0;
        out_hold = 1'b0;
        idle_on = 1'b1;
        bucket_sel = 7'd64;
        pend_len = 0;
        pend_hash = '0;
        pool_used = 0;
        for (int k = 0; k < BUCKETS; k++) chain_head[k] = -1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_bucket_counts();
        test_pool_full();
        test_backpressure();
        test_random(120, 7'd64);
        test_random(100, 7'd5);
        idle_on = 1'b0;
        test_random(80, 7'd1);
        idle_on = 1'b1;
        test_random(100, 7'd100);
        wait_drained();
        if (mismatches == 0)
            $display("string_hash_set_chained_core_test passed");
        else
            $display("string_hash_set_chained_core_test failed");
        $finish;
    end

endmodule
